>>> sv/curvature_feed_limit_stream_defines.svh
// ---------------------------------------------------------------------------
// Curvature feed limit stream: assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ---------------------------------------------------------------------------
`ifndef CURVATURE_FEED_LIMIT_STREAM_DEFINES_SVH
`define CURVATURE_FEED_LIMIT_STREAM_DEFINES_SVH

// Property checked at every rising clock edge.
`define CFLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Antecedent now, consequent in the cycle after.
`define CFLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/cfls_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Curvature feed limit package
// Widths, constants, register indexes and controller/datapath types.
// ---------------------------------------------------------------------------
package cfls_pkg;

  localparam int unsigned ARC_W    = 24;
  localparam int unsigned CURV_W   = 24;
  localparam int unsigned CFG_W    = 24;
  localparam int unsigned SF_W     = 17;
  localparam int unsigned SF_FRAC  = 16;
  localparam int unsigned OUT_W    = 24;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned VALUE_WIDTH_DEF = 24;

  // seconds to minutes
  localparam int unsigned FEED_PER_VEL = 60;

  // max_feed / 60 done as (max_feed >> 2) / 15 with a reciprocal multiply
  localparam int unsigned CAP_PRESHIFT = 2;
  localparam int unsigned CAP_ODD      = FEED_PER_VEL >> CAP_PRESHIFT;
  localparam int unsigned RY_W         = CFG_W - CAP_PRESHIFT;
  localparam int unsigned RECIP_SHIFT  = RY_W + 4;
  localparam int unsigned RECIP_W      = 23;
  localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'((64'd1 << RECIP_SHIFT) / CAP_ODD);
  localparam int unsigned CAP_W        = 19;
  localparam int unsigned PROD_W       = RY_W + RECIP_W;
  localparam int unsigned VEL60_W      = CAP_W + 6;
  localparam int unsigned WIDE_W       = 33;

  // divide accel * 2^24 by curvature, then square root of the quotient
  localparam int unsigned DIVD_W      = CFG_W + CURV_W;
  localparam int unsigned DIV_BITS    = 4;
  localparam int unsigned DIV_STEPS   = DIVD_W / DIV_BITS;
  localparam int unsigned ROOT_W      = DIVD_W / 2;
  localparam int unsigned SREM_W      = ROOT_W + 1;
  localparam int unsigned SQRT_DIGITS = 2;
  localparam int unsigned SQRT_STEPS  = ROOT_W / SQRT_DIGITS;
  localparam int unsigned STEP_W      = $clog2(DIV_STEPS);

  localparam logic [CFG_W-1:0] MIN_CURV_RST  = CFG_W'(1);
  localparam logic [CFG_W-1:0] MAX_FEED_RST  = CFG_W'(80000);
  localparam logic [CFG_W-1:0] MAX_ACCEL_RST = CFG_W'(16000);
  localparam logic [SF_W-1:0]  SAFETY_RST    = SF_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_CURV,
    CFG_MAX_FEED,
    CFG_MAX_ACCEL,
    CFG_SAFETY
  } cfg_idx_e;

  typedef struct packed {
    logic load;
    logic recip;
    logic cap;
    logic div_step;
    logic sqrt_step;
    logic mul;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic bypass;
    logic out_free;
  } dp_stat_t;

endpackage

>>> sv/cfls_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Curvature feed limit stream interfaces
// Valid/ready channels for trajectory samples and limit results.
// ---------------------------------------------------------------------------
interface cfls_in_if;
  import cfls_pkg::*;

  logic              valid;
  logic              ready;
  logic [ARC_W-1:0]  arc_length;
  logic [CURV_W-1:0] curvature;
  logic              last;

  modport source (output valid, arc_length, curvature, last, input ready);
  modport sink   (input valid, arc_length, curvature, last, output ready);
endinterface

interface cfls_out_if;
  import cfls_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] sample_arc;
  logic [OUT_W-1:0] velocity_limit;
  logic [OUT_W-1:0] feed_limit;
  logic [OUT_W-1:0] lowest_feed;
  logic [OUT_W-1:0] lowest_feed_arc;
  logic [OUT_W-1:0] highest_feed;
  logic             set_done;

  modport source (
    output valid, sample_arc, velocity_limit, feed_limit, lowest_feed,
           lowest_feed_arc, highest_feed, set_done,
    input  ready
  );
  modport sink (
    input  valid, sample_arc, velocity_limit, feed_limit, lowest_feed,
           lowest_feed_arc, highest_feed, set_done,
    output ready
  );
endinterface

>>> sv/cfls_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Curvature feed limit controller
// Per sample: recip, cap, divide and root unless bypassed, mul, result load.
// ---------------------------------------------------------------------------
module cfls_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cfls_pkg::dp_stat_t stat_i,
  output cfls_pkg::dp_cmd_t  cmd_o
);
  import cfls_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RECIP,
    ST_CAP,
    ST_DIV,
    ST_SQRT,
    ST_MUL,
    ST_DONE
  } state_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_RECIP;
        end
      end
      ST_RECIP: begin
        cmd_o.recip = 1'b1;
        state_d     = ST_CAP;
      end
      ST_CAP: begin
        cmd_o.cap = 1'b1;
        step_d    = '0;
        state_d   = stat_i.bypass ? ST_MUL : ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          step_d  = '0;
          state_d = ST_SQRT;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (step_q == STEP_W'(SQRT_STEPS - 1)) begin
          step_d  = '0;
          state_d = ST_MUL;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        cmd_o.finish = stat_i.out_free;
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

>>> sv/cfls_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Curvature feed limit datapath
// Config registers, radix-16 divider, radix-4 root, feed multiply, aggregates.
// ---------------------------------------------------------------------------
module cfls_dp #(
  parameter int unsigned VALUE_WIDTH = cfls_pkg::VALUE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cfls_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cfls_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic [cfls_pkg::ARC_W-1:0]     arc_i,
  input  logic [cfls_pkg::CURV_W-1:0]    curv_i,
  input  logic                           last_i,
  input  cfls_pkg::dp_cmd_t              cmd_i,
  output cfls_pkg::dp_stat_t             stat_o,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [cfls_pkg::OUT_W-1:0]     sample_arc_o,
  output logic [cfls_pkg::OUT_W-1:0]     velocity_limit_o,
  output logic [cfls_pkg::OUT_W-1:0]     feed_limit_o,
  output logic [cfls_pkg::OUT_W-1:0]     lowest_feed_o,
  output logic [cfls_pkg::OUT_W-1:0]     lowest_feed_arc_o,
  output logic [cfls_pkg::OUT_W-1:0]     highest_feed_o,
  output logic                           set_done_o
);
  import cfls_pkg::*;

  localparam logic [WIDE_W-1:0] VMaxW = (WIDE_W'(1) << VALUE_WIDTH) - WIDE_W'(1);

  // configuration
  logic [CFG_W-1:0] min_curv_q, max_feed_q, max_accel_q;
  logic [SF_W-1:0]  safety_q;

  // sample and working registers
  logic [ARC_W-1:0]  arc_q;
  logic [CURV_W-1:0] kappa_q;
  logic              last_q;
  logic [DIVD_W-1:0] x_q, x_d;
  logic [CURV_W-1:0] drem_q, drem_d;
  logic [SREM_W-1:0] srem_q, srem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [PROD_W-1:0] prod_q;
  logic [CAP_W-1:0]  vcap_q, vel_q;

  // set aggregates
  logic [VALUE_WIDTH-1:0] run_min_q, run_max_q;
  logic [ARC_W-1:0]       run_arc_q;
  logic                   have_min_q;

  // result register
  logic             out_valid_q;
  logic [OUT_W-1:0] o_arc_q, o_vel_q, o_feed_q, o_min_q, o_min_arc_q, o_max_q;
  logic             o_done_q;

  // divider step
  logic [CURV_W-1:0] div_r;
  logic [CURV_W:0]   div_t;
  logic [DIVD_W-1:0] div_x;
  // root step
  logic [SREM_W-1:0] sq_r;
  logic [SREM_W+1:0] sq_t, sq_trial;
  logic [ROOT_W-1:0] sq_root;
  logic [DIVD_W-1:0] sq_x;
  // cap, velocity, feed
  logic [RY_W-1:0]        recip_y, cap_rem;
  logic [CAP_W-1:0]       cap_q0, vcap_d, vel_pick, vel_sat;
  logic [WIDE_W-1:0]      vel_w, feed_w;
  logic [VEL60_W-1:0]     vel60;
  logic [VALUE_WIDTH-1:0] feed;
  logic                   take_min;
  logic [VALUE_WIDTH-1:0] new_min, new_max;
  logic [ARC_W-1:0]       new_arc;

  assign stat_o.bypass   = (kappa_q == '0) || (CFG_W'(kappa_q) < min_curv_q);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    div_r = drem_q;
    div_x = x_q;
    div_t = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      div_t = {div_r, div_x[DIVD_W-1]};
      div_x = {div_x[DIVD_W-2:0], 1'b0};
      if (div_t >= {1'b0, kappa_q}) begin
        div_r    = CURV_W'(div_t - {1'b0, kappa_q});
        div_x[0] = 1'b1;
      end else begin
        div_r = div_t[CURV_W-1:0];
      end
    end
  end

  always_comb begin
    sq_r     = srem_q;
    sq_root  = root_q;
    sq_x     = x_q;
    sq_t     = '0;
    sq_trial = '0;
    for (int j = 0; j < SQRT_DIGITS; j++) begin
      sq_t     = {sq_r, sq_x[DIVD_W-1 -: 2]};
      sq_x     = {sq_x[DIVD_W-3:0], 2'b00};
      sq_trial = {1'b0, sq_root, 2'b01};
      if (sq_t >= sq_trial) begin
        sq_r    = SREM_W'(sq_t - sq_trial);
        sq_root = {sq_root[ROOT_W-2:0], 1'b1};
      end else begin
        sq_r    = sq_t[SREM_W-1:0];
        sq_root = {sq_root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    x_d    = x_q;
    drem_d = drem_q;
    srem_d = srem_q;
    root_d = root_q;
    if (cmd_i.load) begin
      x_d    = {max_accel_q, CURV_W'(0)};
      drem_d = '0;
      srem_d = '0;
      root_d = '0;
    end else if (cmd_i.div_step) begin
      x_d    = div_x;
      drem_d = div_r;
    end else if (cmd_i.sqrt_step) begin
      x_d    = sq_x;
      srem_d = sq_r;
      root_d = sq_root;
    end
  end

  // floor(max_feed / 60): truncated reciprocal is low by at most one
  assign recip_y = max_feed_q[CFG_W-1:CAP_PRESHIFT];
  assign cap_q0  = prod_q[RECIP_SHIFT +: CAP_W];
  assign cap_rem = recip_y - RY_W'(cap_q0 * CAP_ODD);
  assign vcap_d  = (cap_rem >= RY_W'(CAP_ODD)) ? cap_q0 + CAP_W'(1) : cap_q0;

  assign vel_pick = stat_o.bypass ? vcap_q :
                    ((root_q > ROOT_W'(vcap_q)) ? vcap_q : root_q[CAP_W-1:0]);
  assign vel_w    = WIDE_W'(vel_pick);
  assign vel_sat  = (vel_w > VMaxW) ? VMaxW[CAP_W-1:0] : vel_pick;
  assign vel60    = VEL60_W'(vel_sat * FEED_PER_VEL);

  assign feed_w = WIDE_W'(prod_q[PROD_W-1:SF_FRAC]);
  assign feed   = (feed_w > VMaxW) ? VMaxW[VALUE_WIDTH-1:0] : feed_w[VALUE_WIDTH-1:0];

  assign take_min = !have_min_q || (feed < run_min_q);
  assign new_min  = take_min ? feed : run_min_q;
  assign new_arc  = take_min ? arc_q : run_arc_q;
  assign new_max  = (feed > run_max_q) ? feed : run_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_curv_q  <= MIN_CURV_RST;
      max_feed_q  <= MAX_FEED_RST;
      max_accel_q <= MAX_ACCEL_RST;
      safety_q    <= SAFETY_RST;
      run_min_q   <= '1;
      run_arc_q   <= '0;
      run_max_q   <= '0;
      have_min_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_MIN_CURV:  min_curv_q  <= cfg_wdata_i;
          CFG_MAX_FEED:  max_feed_q  <= cfg_wdata_i;
          CFG_MAX_ACCEL: max_accel_q <= cfg_wdata_i;
          CFG_SAFETY:    safety_q    <= cfg_wdata_i[SF_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.finish) begin
        if (last_q) begin
          run_min_q  <= '1;
          run_arc_q  <= '0;
          run_max_q  <= '0;
          have_min_q <= 1'b0;
        end else begin
          run_min_q  <= new_min;
          run_arc_q  <= new_arc;
          run_max_q  <= new_max;
          have_min_q <= 1'b1;
        end
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    drem_q <= drem_d;
    srem_q <= srem_d;
    root_q <= root_d;
    if (cmd_i.load) begin
      arc_q   <= arc_i;
      kappa_q <= curv_i;
      last_q  <= last_i;
    end
    if (cmd_i.recip) begin
      prod_q <= PROD_W'(recip_y * RECIP_M);
    end else if (cmd_i.mul) begin
      prod_q <= PROD_W'(vel60 * safety_q);
    end
    if (cmd_i.cap) begin
      vcap_q <= vcap_d;
    end
    if (cmd_i.mul) begin
      vel_q <= vel_sat;
    end
    if (cmd_i.finish) begin
      o_arc_q     <= OUT_W'(arc_q);
      o_vel_q     <= OUT_W'(vel_q);
      o_feed_q    <= OUT_W'(feed);
      o_min_q     <= OUT_W'(new_min);
      o_min_arc_q <= OUT_W'(new_arc);
      o_max_q     <= OUT_W'(new_max);
      o_done_q    <= last_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign sample_arc_o      = o_arc_q;
  assign velocity_limit_o  = o_vel_q;
  assign feed_limit_o      = o_feed_q;
  assign lowest_feed_o     = o_min_q;
  assign lowest_feed_arc_o = o_min_arc_q;
  assign highest_feed_o    = o_max_q;
  assign set_done_o        = o_done_q;

endmodule

>>> sv/curvature_feed_limit_stream.sv
// Each sample steps through reciprocal, cap, radix-16 divide, radix-4 root, multiply
// and result load; zero or below-threshold curvature skips the divide and the root.
// A new sample is taken only after the last result is loaded into a free result slot.
// Reset: config registers to listed defaults, set aggregates cleared, no result held.
`timescale 1ns / 1ps
`include "curvature_feed_limit_stream_defines.svh"
// ---------------------------------------------------------------------------
// Curvature feed limit stream
// Centripetal feed limit per trajectory sample with running min/max feed.
// ---------------------------------------------------------------------------
module curvature_feed_limit_stream #(
  parameter int unsigned VALUE_WIDTH = cfls_pkg::VALUE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cfls_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cfls_pkg::CFG_W-1:0]     cfg_wdata_i,
  cfls_in_if.sink                        sample_i,
  cfls_out_if.source                     limit_o
);
  import cfls_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  logic     in_ready;

  assign sample_i.ready = in_ready;

  cfls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  cfls_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .arc_i             (sample_i.arc_length),
    .curv_i            (sample_i.curvature),
    .last_i            (sample_i.last),
    .cmd_i             (dp_cmd),
    .stat_o            (dp_stat),
    .out_ready_i       (limit_o.ready),
    .out_valid_o       (limit_o.valid),
    .sample_arc_o      (limit_o.sample_arc),
    .velocity_limit_o  (limit_o.velocity_limit),
    .feed_limit_o      (limit_o.feed_limit),
    .lowest_feed_o     (limit_o.lowest_feed),
    .lowest_feed_arc_o (limit_o.lowest_feed_arc),
    .highest_feed_o    (limit_o.highest_feed),
    .set_done_o        (limit_o.set_done)
  );

  `CFLS_ASSERT_NEXT(a_busy_after_accept, sample_i.valid && sample_i.ready, !sample_i.ready, "sample taken while busy")
  `CFLS_ASSERT(a_load_into_free_slot, dp_cmd.finish |-> dp_stat.out_free, "result overwrote pending transaction")
  `CFLS_ASSERT(a_valid_from_finish, $rose(limit_o.valid) |-> $past(dp_cmd.finish), "result valid without load")

endmodule

>>> bench/curvature_feed_limit_stream_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Curvature feed limit stream testbench
// Drives trajectory samples through the valid/ready input channel and checks
// every result transaction against a cycle-free predictor of the velocity and
// feed limits and the per-set running min/max feed. A directed table covers
// the corner cases; random phases follow under changing register settings,
// with random stalls on both channels in all but the last phase.
// ---------------------------------------------------------------------------
module curvature_feed_limit_stream_test;
  import cfls_pkg::*;

  localparam int unsigned       CYCLE_LIMIT = 600000;
  localparam int unsigned       DRAIN_WAIT  = 40;
  localparam int unsigned       PHASES      = 8;
  localparam int unsigned       PHASE_ITEMS = 200;
  localparam logic [63:0]       FULL_SCALE  = (64'd1 << VALUE_WIDTH_DEF) - 64'd1;
  localparam logic [OUT_W-1:0]  ALL_ONES    = '1;

  typedef struct packed {
    logic [OUT_W-1:0] sample_arc;
    logic [OUT_W-1:0] velocity_limit;
    logic [OUT_W-1:0] feed_limit;
    logic [OUT_W-1:0] lowest_feed;
    logic [OUT_W-1:0] lowest_feed_arc;
    logic [OUT_W-1:0] highest_feed;
    logic             set_done;
  } limit_t;

  typedef struct {
    bit               is_write;
    cfg_idx_e         reg_idx;
    logic [CFG_W-1:0] value;
    logic [ARC_W-1:0] arc;
    logic [CURV_W-1:0] curv;
    bit               last;
    bit               known;
    logic [OUT_W-1:0] vel;
    logic [OUT_W-1:0] feed;
  } plan_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  cfls_in_if  sample_ch ();
  cfls_out_if limit_ch ();

  curvature_feed_limit_stream dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .sample_i    (sample_ch),
    .limit_o     (limit_ch)
  );

  // predictor state
  logic [CFG_W-1:0] min_curv_q;
  logic [CFG_W-1:0] max_feed_q;
  logic [CFG_W-1:0] max_accel_q;
  logic [SF_W-1:0]  safety_q;
  logic [63:0]      set_min_feed;
  logic [63:0]      set_min_arc;
  logic [63:0]      set_max_feed;
  bit               set_open;

  limit_t    pending_limits[$];
  plan_row_t plan[$];

  int  fail_count;
  int  samples_sent;
  int  results_checked;
  int  sets_closed;
  int  reg_writes;
  int  hold_cycles;
  bit  recv_idle_on;
  bit  send_gaps_on;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_set_state();
    set_min_feed = FULL_SCALE;
    set_min_arc  = '0;
    set_max_feed = '0;
    set_open     = 1'b0;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  function automatic limit_t predict_limit(logic [ARC_W-1:0] arc, logic [CURV_W-1:0] curv,
                                           logic last);
    limit_t      r;
    logic [63:0] vcap;
    logic [63:0] quo;
    logic [63:0] vel;
    logic [63:0] feed;
    vcap = 64'(max_feed_q) / 64'(FEED_PER_VEL);
    if (curv == '0 || curv < min_curv_q) begin
      vel = vcap;
    end else begin
      quo = (64'(max_accel_q) << 24) / 64'(curv);
      vel = floor_sqrt(quo);
      if (vel > vcap) vel = vcap;
    end
    if (vel > FULL_SCALE) vel = FULL_SCALE;
    feed = (vel * 64'(FEED_PER_VEL) * 64'(safety_q)) >> SF_FRAC;
    if (feed > FULL_SCALE) feed = FULL_SCALE;
    if (!set_open || feed < set_min_feed) begin
      set_min_feed = feed;
      set_min_arc  = 64'(arc);
      set_open     = 1'b1;
    end
    if (feed > set_max_feed) set_max_feed = feed;
    r.sample_arc      = arc;
    r.velocity_limit  = vel[OUT_W-1:0];
    r.feed_limit      = feed[OUT_W-1:0];
    r.lowest_feed     = set_min_feed[OUT_W-1:0];
    r.lowest_feed_arc = set_min_arc[OUT_W-1:0];
    r.highest_feed    = set_max_feed[OUT_W-1:0];
    r.set_done        = last;
    if (last) clear_set_state();
    return r;
  endfunction

  function automatic void plan_sample(logic [ARC_W-1:0] arc, logic [CURV_W-1:0] curv,
                                      bit last, bit known = 1'b0,
                                      logic [OUT_W-1:0] vel = '0,
                                      logic [OUT_W-1:0] feed = '0);
    plan_row_t row;
    row.is_write = 1'b0;
    row.reg_idx  = CFG_MIN_CURV;
    row.value    = '0;
    row.arc      = arc;
    row.curv     = curv;
    row.last     = last;
    row.known    = known;
    row.vel      = vel;
    row.feed     = feed;
    plan.insert(plan.size(), row);
  endfunction

  function automatic void plan_write(cfg_idx_e idx, logic [CFG_W-1:0] value);
    plan_row_t row;
    row.is_write = 1'b1;
    row.reg_idx  = idx;
    row.value    = value;
    row.arc      = '0;
    row.curv     = '0;
    row.last     = 1'b0;
    row.known    = 1'b0;
    row.vel      = '0;
    row.feed     = '0;
    plan.insert(plan.size(), row);
  endfunction

  function automatic logic [CFG_W-1:0] pick_reg(int unsigned top);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_W'(top);
      default: return CFG_W'($urandom_range(0, top));
    endcase
  endfunction

  function automatic void check_field(string name, logic [OUT_W-1:0] exp_v,
                                      logic [OUT_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_MIN_CURV:  min_curv_q  = value;
      CFG_MAX_FEED:  max_feed_q  = value;
      CFG_MAX_ACCEL: max_accel_q = value;
      CFG_SAFETY:    safety_q    = value[SF_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    sample_ch.valid <= 1'b0;
    while (pending_limits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic send_sample(logic [ARC_W-1:0] arc, logic [CURV_W-1:0] curv, bit last,
                             bit known = 1'b0, logic [OUT_W-1:0] vel = '0,
                             logic [OUT_W-1:0] feed = '0);
    int     gap;
    limit_t exp_r;
    if (send_gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk_i);
      sample_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    sample_ch.valid      <= 1'b1;
    sample_ch.arc_length <= arc;
    sample_ch.curvature  <= curv;
    sample_ch.last       <= last;
    do @(posedge clk_i); while (!sample_ch.ready);
    exp_r = predict_limit(arc, curv, last);
    if (known) begin
      exp_r.velocity_limit = vel;
      exp_r.feed_limit     = feed;
    end
    pending_limits.insert(pending_limits.size(), exp_r);
    samples_sent++;
  endtask

  function automatic logic [CURV_W-1:0] pick_curvature();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return min_curv_q;
      2:       return (min_curv_q == '0) ? '0 : min_curv_q - 1'b1;
      3:       return '1;
      4, 5:    return CURV_W'($urandom_range(1, 'hFFFF));
      default: return CURV_W'($urandom());
    endcase
  endfunction

  // result side: random stall bursts, plus a long hold-off on request
  initial begin
    int stall_left;
    stall_left     = 0;
    limit_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        limit_ch.ready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        limit_ch.ready <= 1'b0;
        stall_left--;
      end else if (recv_idle_on && $urandom_range(0, 7) == 0) begin
        stall_left     = $urandom_range(1, 8) - 1;
        limit_ch.ready <= 1'b0;
      end else begin
        limit_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    limit_t exp_r;
    if (rst_ni && limit_ch.valid && limit_ch.ready) begin
      if (pending_limits.size() == 0) begin
        $error("result transaction with nothing expected, sample_arc %0d",
               limit_ch.sample_arc);
        fail_count++;
      end else begin
        exp_r = pending_limits.pop_front();
        check_field("sample_arc", exp_r.sample_arc, limit_ch.sample_arc);
        check_field("velocity_limit", exp_r.velocity_limit, limit_ch.velocity_limit);
        check_field("feed_limit", exp_r.feed_limit, limit_ch.feed_limit);
        check_field("lowest_feed", exp_r.lowest_feed, limit_ch.lowest_feed);
        check_field("lowest_feed_arc", exp_r.lowest_feed_arc, limit_ch.lowest_feed_arc);
        check_field("highest_feed", exp_r.highest_feed, limit_ch.highest_feed);
        check_field("set_done", OUT_W'(exp_r.set_done), OUT_W'(limit_ch.set_done));
        results_checked++;
        if (exp_r.set_done) sets_closed++;
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
             pending_limits.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    bit               prev_write;
    logic [CURV_W-1:0] curv;
    bit               last;
    rst_ni               = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = CFG_MIN_CURV;
    cfg_wdata            = '0;
    sample_ch.valid      = 1'b0;
    sample_ch.arc_length = '0;
    sample_ch.curvature  = '0;
    sample_ch.last       = 1'b0;
    fail_count           = 0;
    samples_sent         = 0;
    results_checked      = 0;
    sets_closed          = 0;
    reg_writes           = 0;
    hold_cycles          = 0;
    recv_idle_on         = 1'b1;
    send_gaps_on         = 1'b1;
    min_curv_q           = MIN_CURV_RST;
    max_feed_q           = MAX_FEED_RST;
    max_accel_q          = MAX_ACCEL_RST;
    safety_q             = SAFETY_RST;
    clear_set_state();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: cap 1333, full feed 79980
    plan_sample(24'h000000, 24'h000000, 1'b0, 1'b1, 24'd1333, 24'd79980);
    plan_sample(24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b1, 24'd126, 24'd7560);
    plan_sample(24'h000100, 24'h000001, 1'b0, 1'b1, 24'd1333, 24'd79980);
    plan_sample(24'h000200, 24'hFFFFFF, 1'b0);               // tie keeps earlier arc
    plan_sample(24'h000300, 24'h100000, 1'b1, 1'b1, 24'd505, 24'd30300);
    // zero curvature with zero threshold still takes the cap
    plan_write(CFG_MIN_CURV, 24'h000000);
    plan_sample(24'h000010, 24'h000000, 1'b0, 1'b1, 24'd1333, 24'd79980);
    plan_sample(24'h000020, 24'h800000, 1'b0);
    plan_write(CFG_MIN_CURV, 24'hFFFFFF);
    plan_sample(24'hAAAAAA, 24'hFFFFFE, 1'b0, 1'b1, 24'd1333, 24'd79980);
    plan_sample(24'h555555, 24'hFFFFFF, 1'b1, 1'b1, 24'd126, 24'd7560);
    // safety above one saturates; first sample of a set at full scale
    plan_write(CFG_MIN_CURV, 24'h000001);
    plan_write(CFG_MAX_FEED, 24'hFFFFFF);
    plan_write(CFG_SAFETY, 24'h01FFFF);
    plan_sample(24'h123456, 24'h000000, 1'b0, 1'b1, 24'd279620, ALL_ONES);
    plan_sample(24'h654321, 24'h000000, 1'b1);
    plan_write(CFG_SAFETY, 24'h000000);
    plan_sample(24'h000001, 24'h000400, 1'b0);
    plan_sample(24'h000002, 24'hFFFFFF, 1'b1);
    plan_write(CFG_SAFETY, 24'h010000);
    plan_write(CFG_MAX_ACCEL, 24'h000000);
    plan_sample(24'h000003, 24'h000007, 1'b0, 1'b1, 24'd0, 24'd0);
    plan_write(CFG_MAX_ACCEL, 24'hFFFFFF);
    plan_sample(24'h000004, 24'h000001, 1'b0);
    plan_sample(24'h000005, 24'h000100, 1'b0);
    plan_write(CFG_MAX_FEED, 24'h000000);
    plan_sample(24'h000006, 24'h000001, 1'b1, 1'b1, 24'd0, 24'd0);

    prev_write = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        if (!prev_write) drain();
        write_reg(plan[i].reg_idx, plan[i].value);
      end else begin
        send_sample(plan[i].arc, plan[i].curv, plan[i].last, plan[i].known,
                    plan[i].vel, plan[i].feed);
      end
      prev_write = plan[i].is_write;
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      write_reg(CFG_MIN_CURV, pick_reg('hFFFFFF));
      write_reg(CFG_MAX_FEED, pick_reg('hFFFFFF));
      write_reg(CFG_MAX_ACCEL, pick_reg('hFFFFFF));
      write_reg(CFG_SAFETY, pick_reg('h10000));
      recv_idle_on = (phase != PHASES - 1);
      send_gaps_on = (phase != PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 2 && n == 40) begin
          hold_cycles  = 400;
          send_gaps_on = 1'b0;
        end
        if (phase == 2 && n == 80) send_gaps_on = 1'b1;
        if (phase == 4 && n == 100) begin
          @(negedge clk_i);
          sample_ch.valid <= 1'b0;
          while (pending_limits.size() != 0) @(posedge clk_i);
        end
        curv = pick_curvature();
        last = ($urandom_range(0, 7) == 0);
        send_sample(ARC_W'($urandom()), curv, last);
      end
    end

    drain();
    $display("Sent %0d samples in %0d phases with %0d register writes", samples_sent,
             PHASES + 1, reg_writes);
    $display("Checked %0d results, %0d closed sets, %0d mismatches", results_checked,
             sets_closed, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/cfls_pkg.sv
sv/cfls_if.sv
sv/cfls_ctrl.sv
sv/cfls_dp.sv
sv/curvature_feed_limit_stream.sv
bench/curvature_feed_limit_stream_test.sv
